[design/linear_band_drive_control_assert.svh]
// Assertion macros shared by the checker of the linear band drive controller.
// Holds no logic of its own; the checker takes it by include.
`ifndef LINEAR_BAND_DRIVE_CONTROL_ASSERT_SVH
`define LINEAR_BAND_DRIVE_CONTROL_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LBDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked from the cycle after the antecedent.
`define LBDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/lbdc_pkg.sv]
// Shared widths, codes and types of the linear band drive controller.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lbdc_pkg;

  localparam int XW        = 16;
  localparam int DIFF_W    = XW + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int DVD_W     = 32;
  localparam int DVS_W     = XW;
  localparam int DIV_STEPS = 4;
  localparam int DIV_STAGES = DVD_W / DIV_STEPS;
  localparam int DES_W     = 34;
  localparam int BAND_W    = 15;
  localparam int GAIN_W    = 16;
  localparam int DRV_W     = 8;
  localparam int DELTA_W   = 36;
  localparam int MUL_W     = GAIN_W + DELTA_W;
  localparam int NUM_W     = MUL_W + 1;
  localparam int FRAC_W    = 8;
  localparam int QT_W      = NUM_W - FRAC_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DRIVE_MIN = -127;
  localparam int DRIVE_MAX = 127;

  localparam int CFG_RST_POINT_B_X = 1;
  localparam int CFG_RST_GAIN      = 256;

  // Cycles from the accepting edge to the edge that takes the result.
  localparam int LATENCY = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_A_X       = 3'd0,
    CFG_POINT_B_X       = 3'd1,
    CFG_POINT_A_Y       = 3'd2,
    CFG_POINT_B_Y       = 3'd3,
    CFG_BAND_HALF_WIDTH = 3'd4,
    CFG_GAIN            = 3'd5,
    CFG_DEFAULT_DRIVE   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BAND_INSIDE = 2'd0,
    BAND_ABOVE  = 2'd1,
    BAND_BELOW  = 2'd2
  } band_status_e;

  typedef struct packed {
    logic signed [XW-1:0]     point_a_x;
    logic signed [XW-1:0]     point_b_x;
    logic signed [XW-1:0]     point_a_y;
    logic signed [XW-1:0]     point_b_y;
    logic [BAND_W-1:0]        band_half_width;
    logic signed [GAIN_W-1:0] gain;
    logic signed [DRV_W-1:0]  default_drive;
    logic signed [DIFF_W-1:0] dy;
    logic [DVS_W-1:0]         div_mag;
    logic                     div_neg;
    logic                     degenerate;
  } cfg_t;

  typedef struct packed {
    logic                 q_neg;
    logic signed [XW-1:0] y;
  } div_side_t;

endpackage

`default_nettype wire

[design/lbdc_cfg_regs.sv]
// Configuration registers of the linear band drive controller, plus the
// line terms derived from them. Depends on lbdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbdc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  logic [lbdc_pkg::CFG_IDX_W-1:0]      idx_i,
  input  logic [lbdc_pkg::CFG_DATA_W-1:0]     wdata_i,
  output lbdc_pkg::cfg_t                      cfg_o
);

  lbdc_pkg::cfg_t cfg_q;
  logic signed [lbdc_pkg::DIFF_W-1:0] dx_pts;
  logic signed [lbdc_pkg::DIFF_W-1:0] dy_pts;
  logic [lbdc_pkg::DIFF_W-1:0]        dx_abs;

  assign dx_pts = lbdc_pkg::DIFF_W'($signed(cfg_q.point_b_x))
                - lbdc_pkg::DIFF_W'($signed(cfg_q.point_a_x));
  assign dy_pts = lbdc_pkg::DIFF_W'($signed(cfg_q.point_b_y))
                - lbdc_pkg::DIFF_W'($signed(cfg_q.point_a_y));
  assign dx_abs = dx_pts[lbdc_pkg::DIFF_W-1] ? lbdc_pkg::DIFF_W'(-dx_pts)
                                             : lbdc_pkg::DIFF_W'(dx_pts);

  // The derived terms follow the raw registers in the next cycle; they are
  // first used in the cycle after an item is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.point_a_x       <= '0;
      cfg_q.point_b_x       <= lbdc_pkg::XW'(lbdc_pkg::CFG_RST_POINT_B_X);
      cfg_q.point_a_y       <= '0;
      cfg_q.point_b_y       <= '0;
      cfg_q.band_half_width <= '0;
      cfg_q.gain            <= lbdc_pkg::GAIN_W'(lbdc_pkg::CFG_RST_GAIN);
      cfg_q.default_drive   <= '0;
      cfg_q.dy              <= '0;
      cfg_q.div_mag         <= lbdc_pkg::DVS_W'(lbdc_pkg::CFG_RST_POINT_B_X);
      cfg_q.div_neg         <= 1'b0;
      cfg_q.degenerate      <= 1'b0;
    end else begin
      if (we_i) begin
        unique case (lbdc_pkg::cfg_idx_e'(idx_i))
          lbdc_pkg::CFG_POINT_A_X:       cfg_q.point_a_x <= wdata_i;
          lbdc_pkg::CFG_POINT_B_X:       cfg_q.point_b_x <= wdata_i;
          lbdc_pkg::CFG_POINT_A_Y:       cfg_q.point_a_y <= wdata_i;
          lbdc_pkg::CFG_POINT_B_Y:       cfg_q.point_b_y <= wdata_i;
          lbdc_pkg::CFG_BAND_HALF_WIDTH: begin
            cfg_q.band_half_width <= wdata_i[lbdc_pkg::BAND_W-1:0];
          end
          lbdc_pkg::CFG_GAIN:            cfg_q.gain <= wdata_i;
          lbdc_pkg::CFG_DEFAULT_DRIVE:   begin
            cfg_q.default_drive <= wdata_i[lbdc_pkg::DRV_W-1:0];
          end
          default: ;
        endcase
      end
      cfg_q.dy         <= dy_pts;
      cfg_q.div_mag    <= dx_abs[lbdc_pkg::DVS_W-1:0];
      cfg_q.div_neg    <= dx_pts[lbdc_pkg::DIFF_W-1];
      cfg_q.degenerate <= (dx_pts == '0);
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[design/lbdc_divider.sv]
// Pipelined unsigned restoring divider, four quotient bits per stage,
// carrying side data alongside each item. Depends on lbdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbdc_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [lbdc_pkg::DVD_W-1:0]    dividend_i,
  input  logic [lbdc_pkg::DVS_W-1:0]    divisor_i,
  input  lbdc_pkg::div_side_t           side_i,
  output logic                          valid_o,
  output logic [lbdc_pkg::DVD_W-1:0]    quotient_o,
  output lbdc_pkg::div_side_t           side_o
);

  localparam int NS = lbdc_pkg::DIV_STAGES;
  localparam int RW = lbdc_pkg::DVS_W;
  localparam int AW = lbdc_pkg::DVD_W;

  logic [NS-1:0]       vld_q;
  logic [NS-1:0]       vld_in;
  logic [RW-1:0]       rem_q   [NS];
  logic [AW-1:0]       aq_q    [NS];
  lbdc_pkg::div_side_t side_q  [NS];
  logic [RW-1:0]       rem_in  [NS];
  logic [AW-1:0]       aq_in   [NS];
  lbdc_pkg::div_side_t side_in [NS];
  logic [RW-1:0]       rem_d   [NS];
  logic [AW-1:0]       aq_d    [NS];

  // The dividend shifts out at the top while quotient bits shift in at the
  // bottom; for a nonzero divisor the partial remainder stays below it.
  function automatic logic [RW+AW-1:0] div_steps(input logic [RW-1:0] rem,
                                                 input logic [AW-1:0] aq,
                                                 input logic [RW-1:0] dvs);
    logic [RW:0]   trial;
    logic [RW-1:0] r;
    logic [AW-1:0] a;
    r = rem;
    a = aq;
    for (int i = 0; i < lbdc_pkg::DIV_STEPS; i++) begin
      trial = {r, a[AW-1]};
      a     = {a[AW-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial = trial - {1'b0, dvs};
        a[0]  = 1'b1;
      end
      r = trial[RW-1:0];
    end
    return {r, a};
  endfunction

  always_comb begin
    vld_in     = {vld_q[NS-2:0], valid_i};
    rem_in[0]  = '0;
    aq_in[0]   = dividend_i;
    side_in[0] = side_i;
    for (int s = 1; s < NS; s++) begin
      rem_in[s]  = rem_q[s-1];
      aq_in[s]   = aq_q[s-1];
      side_in[s] = side_q[s-1];
    end
    for (int s = 0; s < NS; s++) begin
      {rem_d[s], aq_d[s]} = div_steps(rem_in[s], aq_in[s], divisor_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_in;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NS; s++) begin
      if (vld_in[s]) begin
        rem_q[s]  <= rem_d[s];
        aq_q[s]   <= aq_d[s];
        side_q[s] <= side_in[s];
      end
    end
  end

  assign valid_o    = vld_q[NS-1];
  assign quotient_o = aq_q[NS-1];
  assign side_o     = side_q[NS-1];

endmodule

`default_nettype wire

[design/lbdc_drive.sv]
// Back end of the linear band drive controller: desired value, band test,
// gain multiply, truncation and clamp, output registers. Depends on lbdc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbdc_drive (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [lbdc_pkg::DVD_W-1:0]         quot_i,
  input  lbdc_pkg::div_side_t                side_i,
  input  lbdc_pkg::cfg_t                     cfg_i,
  output logic                               done_o,
  output logic signed [lbdc_pkg::DRV_W-1:0]  drive_o,
  output logic [1:0]                         band_status_o,
  output logic                               degen_o
);

  localparam int DW  = lbdc_pkg::DES_W;
  localparam int TW  = lbdc_pkg::DELTA_W;
  localparam int MW  = lbdc_pkg::MUL_W;
  localparam int NW  = lbdc_pkg::NUM_W;
  localparam int QW  = lbdc_pkg::QT_W;
  localparam int FW  = lbdc_pkg::FRAC_W;

  // Stage E: desired y on the reference line.
  logic                           ve_q;
  logic signed [DW-1:0]           des_e_q;
  logic signed [lbdc_pkg::XW-1:0] sy_e_q;
  logic signed [DW-1:0]           q_signed;
  logic signed [DW-1:0]           ya_ext;
  logic signed [DW-1:0]           des_e_d;

  assign q_signed = side_i.q_neg ? -$signed({2'b00, quot_i}) : $signed({2'b00, quot_i});
  assign ya_ext   = DW'($signed(cfg_i.point_a_y));
  assign des_e_d  = cfg_i.degenerate ? ya_ext : ya_ext + q_signed;

  // Stage F: band test. The signed deviation past the near band edge is kept
  // so that one multiply serves both sides of the band.
  logic                          vf_q;
  logic signed [TW-1:0]          delta_f_q;
  lbdc_pkg::band_status_e        st_f_q;
  logic signed [TW-1:0]          des_x;
  logic signed [TW-1:0]          y_x;
  logic signed [TW-1:0]          band_x;
  logic signed [TW-1:0]          d_hi;
  logic signed [TW-1:0]          d_lo;
  logic                          above;
  logic                          below;
  logic signed [TW-1:0]          delta_f_d;
  lbdc_pkg::band_status_e        st_f_d;

  assign des_x  = TW'(des_e_q);
  assign y_x    = TW'(sy_e_q);
  assign band_x = $signed(TW'(cfg_i.band_half_width));
  assign d_hi   = des_x + band_x - y_x;
  assign d_lo   = des_x - band_x - y_x;
  assign above  = d_hi[TW-1];
  assign below  = !d_lo[TW-1] && (d_lo != '0);

  always_comb begin
    delta_f_d = '0;
    st_f_d    = lbdc_pkg::BAND_INSIDE;
    if (above) begin
      delta_f_d = d_hi;
      st_f_d    = lbdc_pkg::BAND_ABOVE;
    end else if (below) begin
      delta_f_d = d_lo;
      st_f_d    = lbdc_pkg::BAND_BELOW;
    end
  end

  // Stage G: gain times deviation.
  logic                   vg_q;
  logic signed [MW-1:0]   mul_g_q;
  lbdc_pkg::band_status_e st_g_q;
  logic signed [MW-1:0]   mul_g_d;

  assign mul_g_d = $signed(cfg_i.gain) * delta_f_q;

  // Stage H: add the default drive in Q8.8.
  logic                   vh_q;
  logic signed [NW-1:0]   num_h_q;
  lbdc_pkg::band_status_e st_h_q;
  logic signed [NW-1:0]   num_h_d;

  assign num_h_d = (NW'($signed(cfg_i.default_drive)) <<< FW) + NW'(mul_g_q);

  // Output stage: drop the fraction toward zero, then clamp.
  logic [NW-1:0]          num_adj;
  logic signed [QW-1:0]   quo;
  logic signed [QW-1:0]   sat;
  logic                   done_q;
  logic signed [lbdc_pkg::DRV_W-1:0] drive_q;
  lbdc_pkg::band_status_e st_q;
  logic                   degen_q;

  assign num_adj = NW'(num_h_q) + (num_h_q[NW-1] ? NW'((2 ** FW) - 1) : NW'(0));
  assign quo     = $signed(num_adj[NW-1:FW]);

  always_comb begin
    sat = quo;
    if (quo < QW'(lbdc_pkg::DRIVE_MIN)) begin
      sat = QW'(lbdc_pkg::DRIVE_MIN);
    end
    if (quo > QW'(lbdc_pkg::DRIVE_MAX)) begin
      sat = QW'(lbdc_pkg::DRIVE_MAX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q   <= 1'b0;
      vf_q   <= 1'b0;
      vg_q   <= 1'b0;
      vh_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      ve_q   <= valid_i;
      vf_q   <= ve_q;
      vg_q   <= vf_q;
      vh_q   <= vg_q;
      done_q <= vh_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      des_e_q <= des_e_d;
      sy_e_q  <= side_i.y;
    end
    if (ve_q) begin
      delta_f_q <= delta_f_d;
      st_f_q    <= st_f_d;
    end
    if (vf_q) begin
      mul_g_q <= mul_g_d;
      st_g_q  <= st_f_q;
    end
    if (vg_q) begin
      num_h_q <= num_h_d;
      st_h_q  <= st_g_q;
    end
    if (vh_q) begin
      drive_q <= sat[lbdc_pkg::DRV_W-1:0];
      st_q    <= st_h_q;
      degen_q <= cfg_i.degenerate;
    end
  end

  assign done_o        = done_q;
  assign drive_o       = drive_q;
  assign band_status_o = st_q;
  assign degen_o       = degen_q;

endmodule

`default_nettype wire

[design/linear_band_drive_control.sv]
// Top level of the linear band drive controller: input stages, divider and
// back end. Depends on lbdc_pkg, lbdc_cfg_regs, lbdc_divider and lbdc_drive.
//
// Usage:
//   Items enter on start_i with sensor_x_i and sensor_y_i; one is taken at
//   each rising edge where start_i is high and busy_o is low. Results leave
//   on drive_o, band_status_o and degenerate_line_o, marked by done_o for
//   exactly one cycle each, in the order the items were taken.
//   Each item passes three input stages, eight divider stages of four
//   quotient bits each and five back-end stages. Throughput is one item
//   per clock; busy_o stays low in operation, so a new item may follow in
//   every cycle. Configuration is written through cfg_we_i, cfg_idx_i and
//   cfg_wdata_i; the user must do so only while no items are in flight, as
//   the block does not enforce it. An unknown index is ignored.
//   Reset clears every valid bit and restores the register defaults; busy_o
//   is high during reset and for the first cycle after it.
//   The receiver has no way to stall; every result is shown once.
`timescale 1ns / 1ps
`default_nettype none

module linear_band_drive_control (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [lbdc_pkg::XW-1:0]       sensor_x_i,
  input  logic signed [lbdc_pkg::XW-1:0]       sensor_y_i,
  input  logic                                 cfg_we_i,
  input  logic [lbdc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lbdc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  output logic                                 done_o,
  output logic signed [lbdc_pkg::DRV_W-1:0]    drive_o,
  output logic [1:0]                           band_status_o,
  output logic                                 degenerate_line_o
);

  localparam int SW = lbdc_pkg::DIFF_W;
  localparam int PW = lbdc_pkg::PROD_W;

  lbdc_pkg::cfg_t cfg;

  lbdc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  logic busy_q;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i && !busy_q;

  // Stage A: offset of x from the first line point.
  logic                           va_q;
  logic signed [SW-1:0]           dx_a_q;
  logic signed [lbdc_pkg::XW-1:0] sy_a_q;
  logic signed [SW-1:0]           dx_a_d;

  assign dx_a_d = SW'(sensor_x_i) - SW'($signed(cfg.point_a_x));

  // Stage B: exact product of the x offset and the line's y span.
  logic                           vb_q;
  logic signed [PW-1:0]           prod_b_q;
  logic signed [lbdc_pkg::XW-1:0] sy_b_q;
  logic signed [PW-1:0]           prod_b_d;

  assign prod_b_d = dx_a_q * $signed(cfg.dy);

  // Stage C: magnitude and quotient sign for the unsigned divider.
  logic                        vc_q;
  logic [lbdc_pkg::DVD_W-1:0]  mag_c_q;
  lbdc_pkg::div_side_t         side_c_q;
  logic [PW-1:0]               prod_abs;
  lbdc_pkg::div_side_t         side_c_d;

  assign prod_abs = prod_b_q[PW-1] ? PW'(-prod_b_q) : PW'(prod_b_q);
  assign side_c_d = '{q_neg: prod_b_q[PW-1] ^ cfg.div_neg, y: sy_b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= accept;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_a_q <= dx_a_d;
      sy_a_q <= sensor_y_i;
    end
    if (va_q) begin
      prod_b_q <= prod_b_d;
      sy_b_q   <= sy_a_q;
    end
    if (vb_q) begin
      mag_c_q  <= prod_abs[lbdc_pkg::DVD_W-1:0];
      side_c_q <= side_c_d;
    end
  end

  logic                       vd;
  logic [lbdc_pkg::DVD_W-1:0] quot;
  lbdc_pkg::div_side_t        side_d;

  lbdc_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vc_q),
    .dividend_i (mag_c_q),
    .divisor_i  (cfg.div_mag),
    .side_i     (side_c_q),
    .valid_o    (vd),
    .quotient_o (quot),
    .side_o     (side_d)
  );

  lbdc_drive u_drive (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (vd),
    .quot_i        (quot),
    .side_i        (side_d),
    .cfg_i         (cfg),
    .done_o        (done_o),
    .drive_o       (drive_o),
    .band_status_o (band_status_o),
    .degen_o       (degenerate_line_o)
  );

endmodule

`default_nettype wire

[design/lbdc_checker.sv]
// Port-level checker of the linear band drive controller and its bind.
// Depends on lbdc_pkg and linear_band_drive_control_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "linear_band_drive_control_assert.svh"

module lbdc_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 busy_i,
  input  logic                                 cfg_we_i,
  input  logic [lbdc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lbdc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 done_i,
  input  logic signed [lbdc_pkg::DRV_W-1:0]    drive_i,
  input  logic [1:0]                           band_status_i,
  input  logic                                 degenerate_line_i
);

  logic                                 accept;
  logic signed [lbdc_pkg::XW-1:0]       xa_q;
  logic signed [lbdc_pkg::XW-1:0]       xb_q;
  logic signed [lbdc_pkg::DRV_W-1:0]    dflt_q;
  logic signed [lbdc_pkg::DRV_W-1:0]    exp_inside;

  assign accept = start_i && !busy_i;

  // Shadow copies of the registers the checks need.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xa_q   <= '0;
      xb_q   <= lbdc_pkg::XW'(lbdc_pkg::CFG_RST_POINT_B_X);
      dflt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (lbdc_pkg::cfg_idx_e'(cfg_idx_i))
        lbdc_pkg::CFG_POINT_A_X:     xa_q   <= cfg_wdata_i;
        lbdc_pkg::CFG_POINT_B_X:     xb_q   <= cfg_wdata_i;
        lbdc_pkg::CFG_DEFAULT_DRIVE: dflt_q <= cfg_wdata_i[lbdc_pkg::DRV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    exp_inside = dflt_q;
    if (dflt_q < lbdc_pkg::DRV_W'(lbdc_pkg::DRIVE_MIN)) begin
      exp_inside = lbdc_pkg::DRV_W'(lbdc_pkg::DRIVE_MIN);
    end
    if (dflt_q > lbdc_pkg::DRV_W'(lbdc_pkg::DRIVE_MAX)) begin
      exp_inside = lbdc_pkg::DRV_W'(lbdc_pkg::DRIVE_MAX);
    end
  end

  `LBDC_ASSERT_IMPL(a_done_has_item, clk_i, rst_ni, done_i, $past(accept, lbdc_pkg::LATENCY), "result without an item accepted at the pipeline latency")
  `LBDC_ASSERT_NEXT(a_item_gives_done, clk_i, rst_ni, accept, ##(lbdc_pkg::LATENCY - 1) done_i, "accepted item produced no result at the pipeline latency")
  `LBDC_ASSERT_IMPL(a_inside_default, clk_i, rst_ni, done_i && (band_status_i == lbdc_pkg::BAND_INSIDE), drive_i == exp_inside, "drive inside the band differs from the clamped default")
  `LBDC_ASSERT_IMPL(a_degenerate_flag, clk_i, rst_ni, done_i, degenerate_line_i == (xa_q == xb_q), "degenerate flag disagrees with the line points")

endmodule

bind linear_band_drive_control lbdc_checker u_lbdc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_i            (busy_o),
  .cfg_we_i          (cfg_we_i),
  .cfg_idx_i         (cfg_idx_i),
  .cfg_wdata_i       (cfg_wdata_i),
  .done_i            (done_o),
  .drive_i           (drive_o),
  .band_status_i     (band_status_o),
  .degenerate_line_i (degenerate_line_o)
);

`default_nettype wire
